// File: design/text_line_layout_tab_dbcs_core_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the text line layout core
// Implication checks on the rising clock edge, masked during reset.
// ---------------------------------------------------------------------------
`ifndef TEXT_LINE_LAYOUT_TAB_DBCS_CORE_MACROS_SVH
`define TEXT_LINE_LAYOUT_TAB_DBCS_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define TLTD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define TLTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define TLTD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define TLTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: design/tltd_pkg.sv
// ---------------------------------------------------------------------------
// tltd_pkg
// Shared types and constants of the text line layout core.
// ---------------------------------------------------------------------------
`default_nettype none

package tltd_pkg;

   // column counter width and its saturation value
   localparam int ABS_W = 18;
   localparam logic [ABS_W-1:0] ABS_LIMIT = '1;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_COLUMNS  = 2'd0,
      CSR_TAB_STOP = 2'd1,
      CSR_SCROLL   = 2'd2,
      CSR_ENCODING = 2'd3
   } csr_index_type;

   // encoding codes
   localparam logic [1:0] ENC_SINGLE = 2'd0;
   localparam logic [1:0] ENC_SJIS   = 2'd1;
   localparam logic [1:0] ENC_EUC    = 2'd2;

   // byte codes
   localparam logic [7:0] CHR_NUL   = 8'h00;
   localparam logic [7:0] CHR_TAB   = 8'h09;
   localparam logic [7:0] CHR_LF    = 8'h0a;
   localparam logic [7:0] CHR_SPACE = 8'h20;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIVIDE,
      ST_COMMIT
   } ctl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load_byte;
      logic div_start;
      logic div_step;
      logic commit;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_tab;
      logic is_hold;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// File: design/tltd_ctrl.sv
// ---------------------------------------------------------------------------
// tltd_ctrl
// Sequencer: takes a byte, runs the tab remainder when needed, commits.
// ---------------------------------------------------------------------------
`default_nettype none

module tltd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire tltd_pkg::dp_status_type status,
   output tltd_pkg::ctl_cmd_type        cmd
);
   import tltd_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            if (status.is_tab) begin
               state_in = ST_DIVIDE;
            end else if (status.is_hold || status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_byte = req_valid;
         end
         ST_DECODE: begin
            cmd.div_start = status.is_tab;
            cmd.commit    = !status.is_tab && (status.is_hold || status.out_free);
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// File: design/tltd_dp.sv
// ---------------------------------------------------------------------------
// tltd_dp
// Datapath: settings, column state, tab remainder unit and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tltd_dp #(
   parameter int MAX_COLUMNS = 126
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic [1:0]            csr_index,
   input  wire logic [15:0]           csr_data,
   input  wire logic [7:0]            req_text_byte,
   input  wire logic                  rsp_ready,
   input  wire tltd_pkg::ctl_cmd_type  cmd,
   output tltd_pkg::dp_status_type     status,
   output logic                       rsp_valid,
   output logic [6:0]                 rsp_run_start,
   output logic [6:0]                 rsp_run_count,
   output logic [7:0]                 rsp_run_char,
   output logic [7:0]                 rsp_second_char,
   output logic                       rsp_pair_written,
   output logic                       rsp_line_end,
   output logic [6:0]                 rsp_line_length,
   output logic                       rsp_text_end
);
   import tltd_pkg::*;

   localparam logic [6:0] WIDTH_MIN = 7'd20;
   localparam logic [6:0] WIDTH_MAX = (MAX_COLUMNS > 127) ? 7'd127 : 7'(MAX_COLUMNS);
   localparam logic [4:0] DIV_LAST  = 5'(ABS_W - 1);

   typedef struct packed {
      logic [6:0] run_start;
      logic [6:0] run_count;
      logic [7:0] run_char;
      logic [7:0] second_char;
      logic       pair_written;
      logic       line_end;
      logic [6:0] line_length;
      logic       text_end;
   } result_type;

   // settings
   logic [6:0]  columns_ff;
   logic [8:0]  tab_stop_ff;
   logic [15:0] scroll_ff;
   logic [1:0]  encoding_ff;

   // line state
   logic [7:0]       byte_ff;
   logic [ABS_W-1:0] abs_ff, abs_in;
   logic             lead_pending_ff, lead_pending_in;
   logic [7:0]       lead_byte_ff, lead_byte_in;

   // remainder unit
   logic [7:0]       rem_ff, rem_in;
   logic [ABS_W-1:0] dvd_ff;
   logic [4:0]       cnt_ff;
   logic [8:0]       trial;
   logic [8:0]       trial_diff;

   // result register
   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // decode and arithmetic
   logic [6:0]         width_eff;
   logic [8:0]         tab_eff;
   logic signed [18:0] x;
   logic signed [18:0] w_s;
   logic               end_hit, tab_hit, hold_hit, is_lead;
   logic [ABS_W:0]     sum_one, sum_two, tab_next_wide;
   logic [ABS_W-1:0]   tab_next;
   logic signed [18:0] x1, run_s, run_e, run_len;
   logic               out_load;

   // clamp width and tab stop
   always_comb begin
      priority if (columns_ff < WIDTH_MIN) begin
         width_eff = WIDTH_MIN;
      end else if (columns_ff > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = columns_ff;
      end
      tab_eff = (tab_stop_ff == 9'd0) ? 9'd1 : tab_stop_ff;
   end

   // classify the held byte
   always_comb begin
      unique case (encoding_ff)
         ENC_SJIS: is_lead = (byte_ff >= 8'h81 && byte_ff <= 8'h9f) ||
                             (byte_ff >= 8'he0 && byte_ff <= 8'hfc);
         ENC_EUC:  is_lead = (byte_ff >= 8'ha1 && byte_ff <= 8'hfe);
         default:  is_lead = 1'b0;
      endcase
      end_hit  = (byte_ff == CHR_NUL) || (byte_ff == CHR_LF && !lead_pending_ff);
      tab_hit  = !end_hit && !lead_pending_ff && (byte_ff == CHR_TAB);
      hold_hit = !end_hit && !lead_pending_ff && !tab_hit && is_lead;
   end

   // visible column and saturating advances
   always_comb begin
      x       = $signed({1'b0, abs_ff}) - $signed({3'b000, scroll_ff});
      w_s     = $signed({12'd0, width_eff});
      sum_one = {1'b0, abs_ff} + 19'd1;
      sum_two = {1'b0, abs_ff} + 19'd2;
      tab_next_wide = {1'b0, abs_ff} - {11'd0, rem_ff} + {10'd0, tab_eff};
      tab_next = tab_next_wide[ABS_W] ? ABS_LIMIT : tab_next_wide[ABS_W-1:0];
      x1      = $signed({1'b0, tab_next}) - $signed({3'b000, scroll_ff});
      run_s   = (x < 0) ? 19'sd0 : x;
      run_e   = (x1 > w_s) ? w_s : x1;
      run_len = run_e - run_s;
   end

   // build the result and the next line state
   always_comb begin
      rsp_in          = '0;
      abs_in          = abs_ff;
      lead_pending_in = lead_pending_ff;
      lead_byte_in    = lead_byte_ff;
      priority if (end_hit) begin
         rsp_in.line_end = 1'b1;
         rsp_in.text_end = (byte_ff == CHR_NUL);
         priority if (x < 0) begin
            rsp_in.line_length = 7'd0;
         end else if (x > w_s) begin
            rsp_in.line_length = width_eff;
         end else begin
            rsp_in.line_length = x[6:0];
         end
         abs_in          = '0;
         lead_pending_in = 1'b0;
         lead_byte_in    = 8'd0;
      end else if (lead_pending_ff) begin
         abs_in          = sum_two[ABS_W] ? ABS_LIMIT : sum_two[ABS_W-1:0];
         lead_pending_in = 1'b0;
         lead_byte_in    = 8'd0;
         priority if (x == -19'sd1) begin
            rsp_in.run_count = 7'd1;
            rsp_in.run_char  = CHR_SPACE;
         end else if (x >= 0 && x < w_s - 19'sd1) begin
            rsp_in.run_start    = x[6:0];
            rsp_in.run_count    = 7'd2;
            rsp_in.run_char     = lead_byte_ff;
            rsp_in.second_char  = byte_ff;
            rsp_in.pair_written = 1'b1;
         end else if (x == w_s - 19'sd1) begin
            rsp_in.run_start = x[6:0];
            rsp_in.run_count = 7'd1;
            rsp_in.run_char  = CHR_SPACE;
         end else begin
            rsp_in = '0;
         end
      end else if (tab_hit) begin
         abs_in = tab_next;
         if (run_len > 0) begin
            rsp_in.run_start = run_s[6:0];
            rsp_in.run_count = run_len[6:0];
            rsp_in.run_char  = CHR_SPACE;
         end
      end else if (hold_hit) begin
         lead_pending_in = 1'b1;
         lead_byte_in    = byte_ff;
      end else begin
         abs_in = sum_one[ABS_W] ? ABS_LIMIT : sum_one[ABS_W-1:0];
         if (x >= 0 && x < w_s) begin
            rsp_in.run_start = x[6:0];
            rsp_in.run_count = 7'd1;
            rsp_in.run_char  = byte_ff;
         end
      end
   end

   // one remainder bit per step
   always_comb begin
      trial      = {rem_ff, dvd_ff[ABS_W-1]};
      trial_diff = trial - tab_eff;
      rem_in     = (trial >= tab_eff) ? trial_diff[7:0] : trial[7:0];
   end

   // hand the result word over, or hold it while stalled
   always_comb begin
      out_load = cmd.commit && !hold_hit;
      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_comb begin
      status.is_tab   = tab_hit;
      status.is_hold  = hold_hit;
      status.div_last = (cnt_ff == DIV_LAST);
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // settings registers
   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff  <= 7'd30;
         tab_stop_ff <= 9'd4;
         scroll_ff   <= 16'd0;
         encoding_ff <= ENC_SINGLE;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMNS:  columns_ff  <= csr_data[6:0];
            CSR_TAB_STOP: tab_stop_ff <= csr_data[8:0];
            CSR_SCROLL:   scroll_ff   <= csr_data;
            CSR_ENCODING: encoding_ff <= csr_data[1:0];
            default:      columns_ff  <= columns_ff;
         endcase
      end
   end

   // line state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         abs_ff          <= '0;
         lead_pending_ff <= 1'b0;
         lead_byte_ff    <= 8'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (cmd.commit) begin
            abs_ff          <= abs_in;
            lead_pending_ff <= lead_pending_in;
            lead_byte_ff    <= lead_byte_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load_byte) byte_ff <= req_text_byte;
      if (out_load) rsp_ff <= rsp_in;
      if (cmd.div_start) begin
         rem_ff <= 8'd0;
         dvd_ff <= abs_ff;
         cnt_ff <= 5'd0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         dvd_ff <= {dvd_ff[ABS_W-2:0], 1'b0};
         cnt_ff <= cnt_ff + 5'd1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_run_start    = rsp_ff.run_start;
   assign rsp_run_count    = rsp_ff.run_count;
   assign rsp_run_char     = rsp_ff.run_char;
   assign rsp_second_char  = rsp_ff.second_char;
   assign rsp_pair_written = rsp_ff.pair_written;
   assign rsp_line_end     = rsp_ff.line_end;
   assign rsp_line_length  = rsp_ff.line_length;
   assign rsp_text_end     = rsp_ff.text_end;

endmodule

`default_nettype wire

// File: design/text_line_layout_tab_dbcs_core.sv
// Text line layout core. Bytes enter on req_ (one word per byte) and each byte
// gives at most one result word on rsp_: a run of written cells, or a line end
// with the clipped line length. A lead byte of a double-byte pair gives no word;
// the pair is reported when its trail byte arrives. A plain byte, pair trail
// or line end goes from idle through decode and back to idle; a tab goes from
// decode on to the divide state, where the remainder unit works out the column
// modulo the tab stop one bit per cycle over the 18-bit column counter, and
// then to commit. A finished result sits in an output register, so a stalled
// rsp_ channel holds the block only when a second result is ready to go.
// Settings are written on csr_ between items; csr_ready is always high.
`default_nettype none
`include "text_line_layout_tab_dbcs_core_macros.svh"

// ---------------------------------------------------------------------------
// text_line_layout_tab_dbcs_core
// Top level: settings port, byte input and result output channels.
// ---------------------------------------------------------------------------
module text_line_layout_tab_dbcs_core #(
   parameter int MAX_COLUMNS = 126
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [6:0]       rsp_run_start,
   output logic [6:0]       rsp_run_count,
   output logic [7:0]       rsp_run_char,
   output logic [7:0]       rsp_second_char,
   output logic             rsp_pair_written,
   output logic             rsp_line_end,
   output logic [6:0]       rsp_line_length,
   output logic             rsp_text_end
);
   import tltd_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   tltd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tltd_dp #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_text_byte    (req_text_byte),
      .rsp_ready        (rsp_ready),
      .cmd              (cmd),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_run_start    (rsp_run_start),
      .rsp_run_count    (rsp_run_count),
      .rsp_run_char     (rsp_run_char),
      .rsp_second_char  (rsp_second_char),
      .rsp_pair_written (rsp_pair_written),
      .rsp_line_end     (rsp_line_end),
      .rsp_line_length  (rsp_line_length),
      .rsp_text_end     (rsp_text_end)
   );

   // a committed result never lands on a word still waiting
   `TLTD_ASSERT_SAME(a_commit_free, clock, reset, cmd.commit && !status.is_hold, status.out_free, "result committed over a waiting word")
   // an accepted byte is decoded before the next one is taken
   `TLTD_ASSERT_NEXT(a_one_byte, clock, reset, req_valid && req_ready, !req_ready, "byte taken while another is in work")
   // a pair always covers two cells
   `TLTD_ASSERT_SAME(a_pair_two, clock, reset, rsp_valid && rsp_pair_written, rsp_run_count == 7'd2, "pair word without two cells")
   // a line end writes no cells
   `TLTD_ASSERT_SAME(a_end_empty, clock, reset, rsp_valid && rsp_line_end, rsp_run_count == 7'd0, "line end word with cells")

endmodule

`default_nettype wire
